[sv/bcq_pkg.sv]
// Package for the byte circular queue.
// Holds command and status codes, field widths and the control structs.
// No dependencies.
package bcq_pkg;

    localparam int CMD_W   = 2;
    localparam int DATA_W  = 8;
    localparam int LIMIT_W = 7;
    localparam int STAT_W  = 2;
    localparam int SIZE_W  = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_QUEUE_SIZE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_COPY = 2'd2,
        CMD_MOVE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic fetch;
        logic put;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_stat;

endpackage

[sv/bcq_ctrl.sv]
// Controller state machine for the byte circular queue.
// Sequences item load, ring fetch and result put; depends on bcq_pkg.
module bcq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bcq_pkg::t_dp_stat  i_dp_stat,
    output bcq_pkg::t_ctrl     o_ctrl,
    output logic               o_idle
);
    import bcq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_PUT   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_ctrl.load  = 1'b0;
        o_ctrl.fetch = 1'b0;
        o_ctrl.put   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_ctrl.fetch = 1'b1;
                n_state      = ST_PUT;
            end
            ST_PUT: begin
                if (i_dp_stat.out_free) begin
                    o_ctrl.put = 1'b1;
                    n_state    = i_dp_stat.last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

[sv/bcq_datapath.sv]
// Datapath for the byte circular queue: ring memory, pointers, burst count
// and the output register. Driven by bcq_ctrl; depends on bcq_pkg.
module bcq_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bcq_pkg::t_ctrl               i_ctrl,
    output bcq_pkg::t_dp_stat            o_dp_stat,
    input  logic                         i_cfg_wr,
    input  logic [$clog2(DEPTH)-1:0]     i_cfg_last,
    input  logic [bcq_pkg::CMD_W-1:0]    i_command,
    input  logic [bcq_pkg::DATA_W-1:0]   i_push_data,
    input  logic [bcq_pkg::LIMIT_W-1:0]  i_burst_limit,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bcq_pkg::STAT_W-1:0]   o_status,
    output logic [bcq_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_data_valid,
    output logic                         o_last
);
    import bcq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [PW-1:0]      r_last_idx;
    logic [PW-1:0]      r_front;
    logic [PW-1:0]      r_rear;
    logic [PW-1:0]      r_cursor;
    logic [PW-1:0]      r_addr;
    logic [LIMIT_W-1:0] r_count;
    logic [LIMIT_W-1:0] r_limit;
    t_cmd               r_cmd;
    logic [DATA_W-1:0]  r_push_data;
    t_status            r_status;
    logic [DATA_W-1:0]  r_mem [DEPTH];
    logic [DATA_W-1:0]  r_rd_data;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_dvalid;
    logic               r_out_last;

    logic [PW-1:0]      adv_rear;
    logic [PW-1:0]      adv_cursor;
    logic               full;
    logic               out_free;
    logic               res_valid;
    logic               last_c;
    logic [LIMIT_W:0]   count_inc;

    assign adv_rear   = (r_rear == r_last_idx) ? '0 : r_rear + 1'b1;
    assign adv_cursor = (r_cursor == r_last_idx) ? '0 : r_cursor + 1'b1;
    assign full       = (adv_rear == r_front);
    assign out_free   = !r_out_valid || !i_stall;
    assign res_valid  = (r_cmd != CMD_PUSH) && (r_status == STAT_OK);
    assign count_inc  = {1'b0, r_count} + 1'b1;
    assign last_c     = (r_status != STAT_OK) || (r_cmd == CMD_PUSH) || (r_cmd == CMD_POP)
                        || (r_addr == r_rear) || (count_inc >= {1'b0, r_limit});

    assign o_dp_stat.out_free = out_free;
    assign o_dp_stat.last     = last_c;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fetch && (r_cmd == CMD_PUSH) && !full) begin
            r_mem[adv_rear] <= r_push_data;
        end
        if (i_ctrl.fetch) begin
            r_rd_data <= r_mem[adv_cursor];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd       <= t_cmd'(i_command);
            r_push_data <= i_push_data;
            r_limit     <= (i_burst_limit == '0) ? LIMIT_W'(1) : i_burst_limit;
        end
        if (i_ctrl.fetch) begin
            r_addr <= adv_cursor;
            if (r_cmd == CMD_PUSH) begin
                r_status <= full ? STAT_FULL : STAT_OK;
            end else begin
                r_status <= (r_front == r_rear) ? STAT_EMPTY : STAT_OK;
            end
        end
        if (i_ctrl.put) begin
            r_out_status <= r_status;
            r_out_data   <= res_valid ? r_rd_data : '0;
            r_out_dvalid <= res_valid;
            r_out_last   <= last_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx  <= PW'(DEPTH - 1);
            r_front     <= PW'(DEPTH - 1);
            r_rear      <= PW'(DEPTH - 1);
            r_cursor    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_last_idx <= i_cfg_last;
                r_front    <= i_cfg_last;
                r_rear     <= i_cfg_last;
            end else begin
                if (i_ctrl.fetch && (r_cmd == CMD_PUSH) && !full) begin
                    r_rear <= adv_rear;
                end
                if (i_ctrl.put && res_valid
                        && ((r_cmd == CMD_POP) || ((r_cmd == CMD_MOVE) && last_c))) begin
                    r_front <= r_addr;
                end
            end
            if (i_ctrl.load) begin
                r_cursor <= r_front;
                r_count  <= '0;
            end else if (i_ctrl.put && res_valid) begin
                r_cursor <= r_addr;
                r_count  <= LIMIT_W'(count_inc);
            end
            if (i_ctrl.put) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_data  = r_out_data;
    assign o_data_valid = r_out_dvalid;
    assign o_last       = r_out_last;

endmodule

[sv/byte_circular_queue_top.sv]
// Top level of the byte circular queue: configuration register port,
// controller and datapath. Depends on bcq_pkg, bcq_ctrl and bcq_datapath.
//
//  Channel  | Handshake                 | Beat carries
//  ---------+---------------------------+---------------------------------------
//  input    | i_valid / o_stall         | i_command, i_push_data, i_burst_limit
//  output   | o_valid / i_stall         | o_status, o_read_data, o_data_valid, o_last
//  config   | psel, penable, pwrite ... | queue_size at byte address 0
//
// An item is taken only while the controller is idle. Push and pop pass once
// through load, fetch and put; copy and move load once, then fetch and put
// each byte, the fetch being the registered read of the ring memory. Reset
// empties the queue at a size of DEPTH. A stalled output holds its beat, and
// the controller waits in its put state until the output register frees.
module byte_circular_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcq_pkg::CMD_W-1:0]     i_command,
    input  logic [bcq_pkg::DATA_W-1:0]    i_push_data,
    input  logic [bcq_pkg::LIMIT_W-1:0]   i_burst_limit,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bcq_pkg::STAT_W-1:0]    o_status,
    output logic [bcq_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_data_valid,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcq_pkg::PADDR_W-1:0]   paddr,
    input  logic [bcq_pkg::PDATA_W-1:0]   pwdata,
    output logic [bcq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bcq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    t_ctrl              ctrl;
    t_dp_stat           dp_stat;
    logic               idle;
    logic               cfg_wr;
    logic [SIZE_W-1:0]  wr_val;
    logic [SIZE_W-1:0]  clamped;
    logic [SIZE_W-1:0]  r_queue_size;
    logic [PW-1:0]      cfg_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_SIZE);
    assign wr_val  = pwdata[SIZE_W-1:0];
    assign clamped = (wr_val < SIZE_W'(2))     ? SIZE_W'(2) :
                     (wr_val > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : wr_val;
    assign cfg_last = PW'(clamped - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_size <= SIZE_W'(DEPTH);
        end else if (cfg_wr) begin
            r_queue_size <= clamped;
        end
    end

    assign prdata  = (paddr[2] == REG_QUEUE_SIZE) ? PDATA_W'(r_queue_size) : '0;
    assign o_stall = !idle;

    bcq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_dp_stat (dp_stat),
        .o_ctrl    (ctrl),
        .o_idle    (idle)
    );

    bcq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_dp_stat     (dp_stat),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_last    (cfg_last),
        .i_command     (i_command),
        .i_push_data   (i_push_data),
        .i_burst_limit (i_burst_limit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_data_valid  (o_data_valid),
        .o_last        (o_last)
    );

endmodule

[sv/bcq_checker.sv]
// Port-level checker for the byte circular queue, bound to the top level.
// Depends on bcq_pkg and byte_circular_queue_top.
module bcq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [bcq_pkg::STAT_W-1:0]    o_status,
    input logic [bcq_pkg::DATA_W-1:0]    o_read_data,
    input logic                          o_data_valid,
    input logic                          o_last
);
    import bcq_pkg::*;

    // A beat taken on the input closes the input until its last result is put into the output register.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after an accepted beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data) && $stable(o_last)))
        else $error("stalled output beat changed");

    a_fail_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_last && !o_data_valid))
        else $error("failed command did not give one empty final beat");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data_valid) |-> (o_read_data == '0))
        else $error("read data not zero on a beat without data");

endmodule

bind byte_circular_queue_top bcq_checker u_bcq_checker (.*);

[sim/byte_circular_queue_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for byte_circular_queue_top: directed and random push, pop, copy and move
// commands, checked beat by beat against a queue model kept inside the bench.
// Depends on bcq_pkg and the byte_circular_queue_top RTL.
module byte_circular_queue_top_tb;
    import bcq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        t_cmd                 cmd;
        logic [DATA_W-1:0]    data;
        logic [LIMIT_W-1:0]   limit;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [DATA_W-1:0]    data;
        logic                 dv;
        logic                 last;
    } t_beat;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic [CMD_W-1:0]     i_command     = '0;
    logic [DATA_W-1:0]    i_push_data   = '0;
    logic [LIMIT_W-1:0]   i_burst_limit = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [DATA_W-1:0]    o_read_data;
    logic                 o_data_valid;
    logic                 o_last;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    t_item                cmd_backlog[$];
    t_beat                due_beats[$];

    logic [DATA_W-1:0]    ring_bytes [DEPTH];
    logic [5:0]           head_ptr;
    logic [5:0]           tail_ptr;
    logic [SIZE_W-1:0]    ring_slots;

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_req      = 0;
    int                   hold_served   = 0;
    int                   hold_left     = 0;
    int                   mismatches    = 0;
    int                   cycle_count   = 0;

    byte_circular_queue_top #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_push_data   (i_push_data),
        .i_burst_limit (i_burst_limit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_data_valid  (o_data_valid),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [5:0] ring_next(input logic [5:0] p);
        if ({1'b0, p} >= ring_slots - 7'd1) return 6'd0;
        return p + 6'd1;
    endfunction

    task automatic predict_command(input t_item it);
        logic [5:0] p;
        int         n;
        int         lim;
        logic       done;
        lim = (it.limit == '0) ? 1 : int'(it.limit);
        if (it.cmd == CMD_PUSH) begin
            p = ring_next(tail_ptr);
            if (p == head_ptr) begin
                due_beats.push_back(t_beat'{STAT_FULL, 8'h00, 1'b0, 1'b1});
            end else begin
                tail_ptr = p;
                ring_bytes[p] = it.data;
                due_beats.push_back(t_beat'{STAT_OK, 8'h00, 1'b0, 1'b1});
            end
        end else if (head_ptr == tail_ptr) begin
            due_beats.push_back(t_beat'{STAT_EMPTY, 8'h00, 1'b0, 1'b1});
        end else if (it.cmd == CMD_POP) begin
            head_ptr = ring_next(head_ptr);
            due_beats.push_back(t_beat'{STAT_OK, ring_bytes[head_ptr], 1'b1, 1'b1});
        end else begin
            p = head_ptr;
            n = 0;
            done = 1'b0;
            while (!done) begin
                p = ring_next(p);
                n++;
                done = (p == tail_ptr) || (n >= lim);
                due_beats.push_back(t_beat'{STAT_OK, ring_bytes[p], 1'b1, done});
            end
            if (it.cmd == CMD_MOVE) head_ptr = p;
        end
    endtask

    task automatic write_queue_size(input logic [PDATA_W-1:0] value);
        logic [SIZE_W-1:0] v;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_QUEUE_SIZE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        v = value[SIZE_W-1:0];
        if (v < 2) v = 2;
        if (v > DEPTH) v = DEPTH;
        ring_slots = v;
        head_ptr   = 6'(v - 7'd1);
        tail_ptr   = 6'(v - 7'd1);
        @(negedge i_clk);
    endtask

    task automatic add_cmd(input t_cmd c, input logic [DATA_W-1:0] d,
                           input logic [LIMIT_W-1:0] l);
        cmd_backlog.push_back(t_item'{c, d, l});
    endtask

    task automatic add_random_cmds(input int count, input int push_pct, input int max_lim);
        t_cmd c;
        int   l;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < push_pct) begin
                c = CMD_PUSH;
            end else begin
                case ($urandom_range(2))
                    0:       c = CMD_POP;
                    1:       c = CMD_COPY;
                    default: c = CMD_MOVE;
                endcase
            end
            l = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(max_lim);
            add_cmd(c, DATA_W'($urandom_range(255)), LIMIT_W'(l));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_valid || due_beats.size() != 0);
    endtask

    // Command driver: holds a stalled beat, otherwise offers the next backlog item.
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_command(t_item'{t_cmd'(i_command), i_push_data, i_burst_limit});
            end
            if (!(i_valid && o_stall)) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_command     <= nxt.cmd;
                    i_push_data   <= nxt.data;
                    i_burst_limit <= nxt.limit;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output stall generator.
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = t_beat'{o_status, o_read_data, o_data_valid, o_last};
                if (due_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                end else begin
                    want = due_beats.pop_front();
                    if (got.status != want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.data != want.data) begin
                        mismatches++;
                        $display("%0t: read_data expected %h, actual %h",
                                 $time, want.data, got.data);
                    end
                    if (got.dv != want.dv) begin
                        mismatches++;
                        $display("%0t: data_valid expected %b, actual %b",
                                 $time, want.dv, got.dv);
                    end
                    if (got.last != want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b, actual %b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (hold_served != hold_req) begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("byte_circular_queue_top_tb: errors");
            $finish;
        end
    end

    initial begin
        ring_slots = DEPTH;
        head_ptr   = 6'(DEPTH - 1);
        tail_ptr   = 6'(DEPTH - 1);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 53;
        add_cmd(CMD_POP,  8'h00, 7'd0);
        add_cmd(CMD_COPY, 8'h00, 7'd0);
        add_cmd(CMD_MOVE, 8'h00, 7'd64);
        add_cmd(CMD_PUSH, 8'h00, 7'd0);
        add_cmd(CMD_PUSH, 8'hFF, 7'd0);
        add_cmd(CMD_PUSH, 8'h5A, 7'd0);
        add_cmd(CMD_COPY, 8'h00, 7'd0);
        add_cmd(CMD_COPY, 8'h00, 7'd64);
        add_cmd(CMD_POP,  8'h00, 7'd0);
        add_cmd(CMD_MOVE, 8'h00, 7'd64);
        add_cmd(CMD_MOVE, 8'h00, 7'd1);
        wait_drained();

        write_queue_size(2);
        add_cmd(CMD_PUSH, 8'hA5, 7'd0);
        add_cmd(CMD_PUSH, 8'h3C, 7'd0);
        add_cmd(CMD_COPY, 8'h00, 7'd2);
        add_cmd(CMD_MOVE, 8'h00, 7'd0);
        add_cmd(CMD_POP,  8'h00, 7'd0);
        add_cmd(CMD_PUSH, 8'h81, 7'd0);
        add_cmd(CMD_POP,  8'h00, 7'd0);
        wait_drained();

        write_queue_size(1);
        add_cmd(CMD_PUSH, 8'h7E, 7'd0);
        add_cmd(CMD_PUSH, 8'h01, 7'd0);
        add_cmd(CMD_MOVE, 8'h00, 7'd64);
        wait_drained();

        write_queue_size(5);
        add_random_cmds(40, 50, 6);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 12;
        write_queue_size(64);
        add_random_cmds(70, 100, 64);
        add_random_cmds(30, 45, 64);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_queue_size(33);
        hold_req++;
        add_random_cmds(30, 55, 34);
        wait_drained();

        write_queue_size(100);
        add_random_cmds(10, 60, 64);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_beats.size() == 0) begin
            $display("byte_circular_queue_top_tb: clean");
        end else begin
            $display("byte_circular_queue_top_tb: errors");
        end
        $finish;
    end

endmodule
